[src/assert_macros.svh]
// Assertion helper macros for the waypoint path block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/cwpi_pkg.sv]
// ----------------------------------------------------------------------------
// cwpi_pkg
// Shared types, constants and the cosine ease table of the path interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package cwpi_pkg;
	localparam int MAX_WP = 16;
	localparam int WP_AW = $clog2(MAX_WP);
	localparam int WP_CW = $clog2(MAX_WP + 1);
	localparam int EASE_N = 256;
	localparam int EASE_AW = $clog2(EASE_N);
	localparam int COORD_W = 24;
	localparam int NCOORD = 6;
	localparam int CI_W = 3;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;
	localparam logic [1:0] MODE_STOP = 2'd3;

	localparam logic CFG_SPEED = 1'b0;
	localparam logic CFG_LOOP = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;     // capture input transaction
		logic div_start;   // begin the increment division
		logic div_step;    // one quotient bit
		logic prog_upd;    // saturate progress, look up weight
		logic blend_mul;   // multiply difference of coordinate ci
		logic blend_wr;    // round and store coordinate ci
		logic [CI_W-1:0] ci;
		logic out_load;    // present result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic logic [15:0] ease_half(input int unsigned i);
		longint unsigned theta, th2, term, s;
		theta = (64'd843314857 * 64'(i)) / EASE_N;
		th2 = (theta * theta) >> 28;
		term = th2 / 2;
		s = term;
		for (int k = 2; k <= 7; k++) begin
			term = ((term * th2) >> 28) / 64'((2 * k - 1) * (2 * k));
			if ((k % 2) == 0) s = s - term;
			else s = s + term;
		end
		s = (s + 64'd4096) >> 13;
		return (s > 64'd65535) ? 16'hFFFF : s[15:0];
	endfunction

	// cosine ease weights, Q0.16, mirrored above the midpoint
	function automatic logic [16*EASE_N-1:0] ease_build();
		logic [16*EASE_N-1:0] t;
		int unsigned w;
		t = '0;
		for (int i = 0; i < EASE_N; i++) begin
			if (2 * i <= EASE_N) w = 32'(ease_half(i));
			else w = 32'd65536 - 32'(ease_half(EASE_N - i));
			if (w > 32'd65535) w = 32'd65535;
			t[i*16+:16] = w[15:0];
		end
		return t;
	endfunction

	localparam logic [16*EASE_N-1:0] EASE_LUT = ease_build();
endpackage
`default_nettype wire

[src/cwpi_ctrl.sv]
// ----------------------------------------------------------------------------
// cwpi_ctrl
// Sequencer: mode decode, playback state, divider and blend scheduling.
// ----------------------------------------------------------------------------
`default_nettype none
module cwpi_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic [1:0] mode,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic loop_enable,
	input  cwpi_pkg::sts_t sts,
	input  wire logic sat_done,
	output cwpi_pkg::cmd_t cmd,
	output logic [cwpi_pkg::WP_CW-1:0] count_q,
	output logic [cwpi_pkg::WP_AW-1:0] seg_q,
	output logic playing_q
);
	typedef enum logic [2:0] {S_IDLE, S_DIV0, S_DIV, S_PROG, S_MUL, S_WR, S_OUT} state_t;
	state_t state_q;
	logic [cwpi_pkg::CI_W-1:0] ci_q;
	logic accept, can_tick;
	logic [cwpi_pkg::WP_CW-1:0] seg_n;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign can_tick = playing_q && ({1'b0, seg_q} + 1'b1 < count_q);
	assign seg_n = {1'b0, seg_q} + 1'b1;

	always_comb begin
		cmd = '0;
		cmd.ci = ci_q;
		cmd.load_in = accept;
		cmd.div_start = (state_q == S_DIV0);
		cmd.div_step = (state_q == S_DIV);
		cmd.prog_upd = (state_q == S_PROG);
		cmd.blend_mul = (state_q == S_MUL);
		cmd.blend_wr = (state_q == S_WR);
		cmd.out_load = (state_q == S_OUT);
	end

	// state and playback registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ci_q <= '0;
			count_q <= '0;
			seg_q <= '0;
			playing_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							cwpi_pkg::MODE_APPEND: begin
								if (count_q < cwpi_pkg::WP_CW'(cwpi_pkg::MAX_WP))
									count_q <= count_q + 1'b1;
							end
							cwpi_pkg::MODE_START: begin
								playing_q <= 1'b1;
								seg_q <= '0;
							end
							cwpi_pkg::MODE_STOP: playing_q <= 1'b0;
							default: if (can_tick) state_q <= S_DIV0;
						endcase
					end
				end
				S_DIV0: state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_PROG;
				S_PROG: begin
					ci_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_WR;
				S_WR: begin
					if (ci_q == cwpi_pkg::CI_W'(cwpi_pkg::NCOORD - 1)) begin
						state_q <= S_OUT;
						if (sat_done) begin
							if (seg_n + 1'b1 == count_q) begin
								playing_q <= loop_enable;
								seg_q <= loop_enable ? '0 : seg_n[cwpi_pkg::WP_AW-1:0];
							end else begin
								seg_q <= seg_n[cwpi_pkg::WP_AW-1:0];
							end
						end
					end else begin
						ci_q <= ci_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[src/cwpi_dp.sv]
// ----------------------------------------------------------------------------
// cwpi_dp
// Datapath: waypoint store, serial divider, progress, shared blend multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module cwpi_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cwpi_pkg::cmd_t cmd,
	output cwpi_pkg::sts_t sts,
	output logic sat_done,
	input  wire logic [1:0] mode,
	input  wire logic [15:0] dt,
	input  wire logic signed [23:0] pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
	input  wire logic [15:0] travel_time,
	input  wire logic [15:0] speed_scale,
	input  wire logic [cwpi_pkg::WP_CW-1:0] count_q,
	input  wire logic [cwpi_pkg::WP_AW-1:0] seg_q,
	input  wire logic playing_q,
	input  wire logic out_stall,
	output logic out_valid,
	output logic signed [23:0] out_pos_x, out_pos_y, out_pos_z,
	output logic signed [23:0] out_rot_x, out_rot_y, out_rot_z,
	output logic [3:0] segment_index,
	output logic still_active
);
	logic [cwpi_pkg::COORD_W*cwpi_pkg::NCOORD+15:0] wp_mem [cwpi_pkg::MAX_WP];
	logic [cwpi_pkg::COORD_W*cwpi_pkg::NCOORD+15:0] a_q, b_q;
	logic [31:0] num_q;
	logic [15:0] tt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0] bit_q;
	logic [16:0] prog_q;
	logic [16:0] w_q;
	logic signed [42:0] prod_q;
	logic signed [23:0] res_q [cwpi_pkg::NCOORD];
	logic [32:0] trial;
	logic [17:0] np;
	logic signed [24:0] diff;
	logic signed [23:0] ca, cb;
	logic signed [42:0] p;
	logic signed [26:0] q;

	assign sts.div_done = (bit_q == 6'd0);
	assign sat_done = (prog_q == 17'h10000);

	// waypoint store: append at fill count, fetch segment pair on tick
	always_ff @(posedge clk) begin
		if (cmd.load_in && mode == cwpi_pkg::MODE_APPEND &&
		    count_q < cwpi_pkg::WP_CW'(cwpi_pkg::MAX_WP))
			wp_mem[count_q[cwpi_pkg::WP_AW-1:0]] <=
				{travel_time, rot_z, rot_y, rot_x, pos_z, pos_y, pos_x};
		if (cmd.div_start) begin
			a_q <= wp_mem[seg_q];
			b_q <= wp_mem[seg_q + 1'b1];
		end
	end

	// restoring divider, one quotient bit a cycle
	assign trial = {rem_q[31:0], num_q[31]} - {17'd0, tt_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			prog_q <= '0;
		end else begin
			if (cmd.load_in && mode == cwpi_pkg::MODE_START) prog_q <= '0;
			if (cmd.div_start) bit_q <= 6'd32;
			else if (cmd.div_step && bit_q != 0) bit_q <= bit_q - 1'b1;
			if (cmd.prog_upd) prog_q <= np[16:0];
			if (cmd.out_load && sat_done) prog_q <= '0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load_in) num_q <= 32'(speed_scale) * 32'(dt);
		if (cmd.div_start) begin
			tt_q <= wp_mem[seg_q + 1'b1][cwpi_pkg::COORD_W*cwpi_pkg::NCOORD+:16];
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step && bit_q != 0) begin
			num_q <= {num_q[30:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], num_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// saturated progress and ease weight
	always_comb begin
		if (tt_q == 16'd0 || quo_q > 32'h10000) np = 18'h10000;
		else np = 18'(prog_q) + 18'(quo_q[16:0]);
		if (np > 18'h10000) np = 18'h10000;
	end
	always_ff @(posedge clk) begin
		if (cmd.prog_upd) begin
			if (np[16]) w_q <= 17'h10000;
			else w_q <= {1'b0, cwpi_pkg::EASE_LUT[{np[15:8], 4'd0}+:16]};
		end
	end

	// shared blend multiplier, one coordinate per pass
	always_comb begin
		ca = a_q[cmd.ci*cwpi_pkg::COORD_W+:cwpi_pkg::COORD_W];
		cb = b_q[cmd.ci*cwpi_pkg::COORD_W+:cwpi_pkg::COORD_W];
		diff = 25'(cb) - 25'(ca);
		p = prod_q + 43'sd32768;
		q = 27'(p >>> 16);
	end
	always_ff @(posedge clk) begin
		if (cmd.blend_mul) prod_q <= 43'(diff) * $signed({1'b0, w_q});
		if (cmd.blend_wr) res_q[cmd.ci] <= 24'(27'(ca) + q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pos_x <= res_q[0];
			out_pos_y <= res_q[1];
			out_pos_z <= res_q[2];
			out_rot_x <= res_q[3];
			out_rot_y <= res_q[4];
			out_rot_z <= res_q[5];
			segment_index <= 4'(seg_q);
			still_active <= playing_q;
		end
	end
endmodule
`default_nettype wire

[src/cosine_waypoint_path_interpolator.sv]
// ----------------------------------------------------------------------------
// Cosine-eased waypoint path player.
// Input channel (in_valid/in_stall) carries mode, dt, a waypoint pose and
// travel_time. Append, start and stop give no result.
// A tick with a next waypoint gives one result on the output channel
// (out_valid/out_stall): pose, segment_index and still_active.
// A tick is processed in order: table fetch, the bit-serial increment
// divider, progress and ease lookup, the shared multiplier over six
// coordinates, and a load of the result register. No new transaction is
// taken until the result register is loaded, so ticks do not overlap.
// A tick while idle or without a next waypoint gives no result.
// Reset clears playback, fill count and out_valid; result data and the
// waypoint store hold nothing valid until written. While a result waits
// under out_stall, new input is held off by in_stall.
// Configuration: cfg_we, cfg_index, cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cosine_waypoint_path_interpolator (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic [1:0] mode,
	input  wire logic [15:0] dt,
	input  wire logic signed [23:0] pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
	input  wire logic [15:0] travel_time,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [23:0] out_pos_x, out_pos_y, out_pos_z,
	output logic signed [23:0] out_rot_x, out_rot_y, out_rot_z,
	output logic [3:0] segment_index,
	output logic still_active
);
	cwpi_pkg::cmd_t cmd;
	cwpi_pkg::sts_t sts;
	logic sat_done, playing_q;
	logic [15:0] speed_q;
	logic loop_q;
	logic [cwpi_pkg::WP_CW-1:0] count_q;
	logic [cwpi_pkg::WP_AW-1:0] seg_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd256;
			loop_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == cwpi_pkg::CFG_SPEED) speed_q <= cfg_data;
			else loop_q <= cfg_data[0];
		end
	end

	cwpi_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .mode, .out_valid, .out_stall,
		.loop_enable(loop_q), .sts, .sat_done, .cmd, .count_q, .seg_q, .playing_q
	);

	cwpi_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .sat_done, .mode, .dt,
		.pos_x, .pos_y, .pos_z, .rot_x, .rot_y, .rot_z, .travel_time,
		.speed_scale(speed_q), .count_q, .seg_q, .playing_q, .out_stall,
		.out_valid, .out_pos_x, .out_pos_y, .out_pos_z,
		.out_rot_x, .out_rot_y, .out_rot_z, .segment_index, .still_active
	);

	`ASSERT_IMPL(a_fill, clk, arst_n, 1'b1, count_q <= cwpi_pkg::WP_CW'(cwpi_pkg::MAX_WP), "fill count overflow")
	`ASSERT_IMPL(a_busy, clk, arst_n, cmd.blend_mul, in_stall, "input taken during blend")
	`ASSERT_NEXT(a_res, clk, arst_n, cmd.out_load, out_valid, "result not presented")
endmodule
`default_nettype wire
